@@ rtl/cpu_alu_flags_condition_unit_core_defines.svh @@
// Assertion macros shared by the ALU flags and condition unit RTL.
// Define ASSERT_OFF to compile every assertion away; no other dependencies.
`ifndef CPU_ALU_FLAGS_CONDITION_UNIT_CORE_DEFINES_SVH
`define CPU_ALU_FLAGS_CONDITION_UNIT_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled while reset is asserted.
`define CAFCU_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CAFCU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define CAFCU_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define CAFCU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ rtl/cafcu_pkg.sv @@
// Types and constants for the ALU flags and condition unit.
// Used by the channel interfaces and every RTL module; no dependencies.
package cafcu_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned CMD_W   = 4;
  localparam int unsigned COND_W  = 4;

  // Operation codes.
  typedef enum logic [CMD_W-1:0] {
    CMD_ADD   = 4'd0,
    CMD_SUB   = 4'd1,
    CMD_CMP   = 4'd2,
    CMD_AND   = 4'd3,
    CMD_OR    = 4'd4,
    CMD_XOR   = 4'd5,
    CMD_CLR   = 4'd6,
    CMD_EXTB  = 4'd7,
    CMD_EXTBU = 4'd8,
    CMD_EXTH  = 4'd9,
    CMD_EXTHU = 4'd10,
    CMD_ASL2  = 4'd11,
    CMD_CTEST = 4'd12,
    CMD_MOVE  = 4'd13,
    CMD_ADDNF = 4'd14
  } cmd_t;

  // Branch condition codes.
  typedef enum logic [COND_W-1:0] {
    COND_LT = 4'd0,
    COND_GT = 4'd1,
    COND_GE = 4'd2,
    COND_LE = 4'd3,
    COND_CS = 4'd4,
    COND_HI = 4'd5,
    COND_CC = 4'd6,
    COND_LS = 4'd7,
    COND_EQ = 4'd8,
    COND_NE = 4'd9
  } cond_t;

  // Status flags; Z sits in bit 0 and V in bit 3.
  typedef struct packed {
    logic v;
    logic c;
    logic n;
    logic z;
  } flags_t;

  // One operation as held in the input register.
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [DATA_W-1:0] operand_a;
    logic [DATA_W-1:0] operand_b;
    logic [COND_W-1:0] cond_code;
  } in_item_t;

  // One result as held in the result register.
  typedef struct packed {
    logic [DATA_W-1:0] result;
    logic              writes_back;
    flags_t            flags_out;
    logic              cond_true;
  } out_item_t;

endpackage

@@ rtl/cafcu_ifs.sv @@
// Valid/ready channel interfaces for operations and results.
// Depends on cafcu_pkg for field widths; flags_out is a plain 4-bit vector.
interface cafcu_in_if;
  logic                            valid;
  logic                            ready;
  logic [cafcu_pkg::CMD_W-1:0]     cmd;
  logic [cafcu_pkg::DATA_W-1:0]    operand_a;
  logic [cafcu_pkg::DATA_W-1:0]    operand_b;
  logic [cafcu_pkg::COND_W-1:0]    cond_code;

  modport source (output valid, cmd, operand_a, operand_b, cond_code, input ready);
  modport sink   (input valid, cmd, operand_a, operand_b, cond_code, output ready);
endinterface

interface cafcu_out_if;
  logic                            valid;
  logic                            ready;
  logic [cafcu_pkg::DATA_W-1:0]    result;
  logic                            writes_back;
  logic [3:0]                      flags_out;
  logic                            cond_true;

  modport source (output valid, result, writes_back, flags_out, cond_true, input ready);
  modport sink   (input valid, result, writes_back, flags_out, cond_true, output ready);
endinterface

@@ rtl/cafcu_in_stage.sv @@
// Input register: captures one operation per transfer on the input channel.
// Depends on cafcu_pkg and cafcu_in_if.
module cafcu_in_stage (
  input  logic                clk,
  input  logic                rst_n,
  cafcu_in_if.sink            in_ch,
  input  logic                advance,
  output logic                item_valid,
  output cafcu_pkg::in_item_t item
);

  logic                valid_r;
  logic                valid_nxt;
  cafcu_pkg::in_item_t item_r;
  logic                take;

  // The register can take a new operation when empty or when its content moves on.
  assign in_ch.ready = !valid_r || advance;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset; it is qualified by the valid bit.
  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= '{cmd:       in_ch.cmd,
                  operand_a: in_ch.operand_a,
                  operand_b: in_ch.operand_b,
                  cond_code: in_ch.cond_code};
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

@@ rtl/cafcu_exec.sv @@
// Single-pass ALU datapath: result, next flags and branch condition.
// Depends on cafcu_pkg; purely combinational.
module cafcu_exec (
  input  cafcu_pkg::in_item_t  item,
  input  cafcu_pkg::flags_t    flags_q,
  output cafcu_pkg::out_item_t res,
  output cafcu_pkg::flags_t    flags_nxt
);

  logic [cafcu_pkg::DATA_W-1:0] a;
  logic [cafcu_pkg::DATA_W-1:0] b;
  logic [cafcu_pkg::DATA_W:0]   sum_ext;
  logic [cafcu_pkg::DATA_W:0]   diff_ext;
  logic [cafcu_pkg::DATA_W-1:0] sum;
  logic [cafcu_pkg::DATA_W-1:0] diff;
  logic [cafcu_pkg::DATA_W-1:0] and_v;
  logic [cafcu_pkg::DATA_W-1:0] or_v;
  logic [cafcu_pkg::DATA_W-1:0] xor_v;
  logic [cafcu_pkg::DATA_W-1:0] asl_v;
  logic                         add_ovf;
  logic                         sub_ovf;
  logic                         lt;
  logic                         cond_hit;
  logic [cafcu_pkg::DATA_W-1:0] res_val;
  logic                         wb;
  logic                         ct;
  cafcu_pkg::flags_t            f;

  assign a = item.operand_a;
  assign b = item.operand_b;

  // One shared adder and one subtractor; the extra top bit is carry or borrow.
  assign sum_ext  = {1'b0, a} + {1'b0, b};
  assign diff_ext = {1'b0, a} - {1'b0, b};
  assign sum      = sum_ext[cafcu_pkg::DATA_W-1:0];
  assign diff     = diff_ext[cafcu_pkg::DATA_W-1:0];
  assign add_ovf  = ~(a[cafcu_pkg::DATA_W-1] ^ b[cafcu_pkg::DATA_W-1])
                    & (a[cafcu_pkg::DATA_W-1] ^ sum[cafcu_pkg::DATA_W-1]);
  assign sub_ovf  = (a[cafcu_pkg::DATA_W-1] ^ b[cafcu_pkg::DATA_W-1])
                    & (a[cafcu_pkg::DATA_W-1] ^ diff[cafcu_pkg::DATA_W-1]);

  assign and_v = a & b;
  assign or_v  = a | b;
  assign xor_v = a ^ b;
  assign asl_v = {a[cafcu_pkg::DATA_W-3:0], 2'b00};

  // Branch condition on the stored flags; unknown codes are false.
  assign lt = flags_q.n ^ flags_q.v;

  always_comb begin
    case (cafcu_pkg::cond_t'(item.cond_code))
      cafcu_pkg::COND_LT: cond_hit = lt;
      cafcu_pkg::COND_GT: cond_hit = !(lt || flags_q.z);
      cafcu_pkg::COND_GE: cond_hit = !lt;
      cafcu_pkg::COND_LE: cond_hit = lt || flags_q.z;
      cafcu_pkg::COND_CS: cond_hit = flags_q.c;
      cafcu_pkg::COND_HI: cond_hit = !(flags_q.c || flags_q.z);
      cafcu_pkg::COND_CC: cond_hit = !flags_q.c;
      cafcu_pkg::COND_LS: cond_hit = flags_q.c || flags_q.z;
      cafcu_pkg::COND_EQ: cond_hit = flags_q.z;
      cafcu_pkg::COND_NE: cond_hit = !flags_q.z;
      default:            cond_hit = 1'b0;
    endcase
  end

  // Operation select and flag update.
  always_comb begin
    res_val = '0;
    wb      = 1'b1;
    ct      = 1'b0;
    f       = flags_q;
    case (cafcu_pkg::cmd_t'(item.cmd))
      cafcu_pkg::CMD_ADD: begin
        res_val = sum;
        f = '{v: add_ovf, c: sum_ext[cafcu_pkg::DATA_W],
              n: sum[cafcu_pkg::DATA_W-1], z: (sum == '0)};
      end
      cafcu_pkg::CMD_SUB: begin
        res_val = diff;
        f = '{v: sub_ovf, c: diff_ext[cafcu_pkg::DATA_W],
              n: diff[cafcu_pkg::DATA_W-1], z: (diff == '0)};
      end
      cafcu_pkg::CMD_CMP: begin
        wb = 1'b0;
        f = '{v: sub_ovf, c: diff_ext[cafcu_pkg::DATA_W],
              n: diff[cafcu_pkg::DATA_W-1], z: (diff == '0)};
      end
      cafcu_pkg::CMD_AND: begin
        res_val = and_v;
        f = '{v: 1'b0, c: flags_q.c, n: and_v[cafcu_pkg::DATA_W-1], z: (and_v == '0)};
      end
      cafcu_pkg::CMD_OR: begin
        res_val = or_v;
        f = '{v: 1'b0, c: flags_q.c, n: or_v[cafcu_pkg::DATA_W-1], z: (or_v == '0)};
      end
      cafcu_pkg::CMD_XOR: begin
        res_val = xor_v;
        f = '{v: 1'b0, c: flags_q.c, n: xor_v[cafcu_pkg::DATA_W-1], z: (xor_v == '0)};
      end
      cafcu_pkg::CMD_CLR: begin
        res_val = '0;
        f = '{v: 1'b0, c: 1'b0, n: 1'b0, z: 1'b1};
      end
      cafcu_pkg::CMD_EXTB: begin
        res_val = {{(cafcu_pkg::DATA_W-8){a[7]}}, a[7:0]};
      end
      cafcu_pkg::CMD_EXTBU: begin
        res_val = {{(cafcu_pkg::DATA_W-8){1'b0}}, a[7:0]};
      end
      cafcu_pkg::CMD_EXTH: begin
        res_val = {{(cafcu_pkg::DATA_W-16){a[15]}}, a[15:0]};
      end
      cafcu_pkg::CMD_EXTHU: begin
        res_val = {{(cafcu_pkg::DATA_W-16){1'b0}}, a[15:0]};
      end
      cafcu_pkg::CMD_ASL2: begin
        res_val = asl_v;
        f = '{v: flags_q.v, c: flags_q.c,
              n: asl_v[cafcu_pkg::DATA_W-1], z: (asl_v == '0)};
      end
      cafcu_pkg::CMD_CTEST: begin
        wb = 1'b0;
        ct = cond_hit;
      end
      cafcu_pkg::CMD_MOVE: begin
        res_val = b;
      end
      cafcu_pkg::CMD_ADDNF: begin
        res_val = sum;
      end
      default: begin
        wb = 1'b0;
      end
    endcase
  end

  // Nothing is reported in the result field when nothing is written back.
  assign res = '{result:      (wb ? res_val : '0),
                 writes_back: wb,
                 flags_out:   f,
                 cond_true:   ct};
  assign flags_nxt = f;

endmodule

@@ rtl/cafcu_out_stage.sv @@
// Result register driving the result channel.
// Depends on cafcu_pkg and cafcu_out_if.
module cafcu_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  cafcu_pkg::out_item_t res,
  output logic                 free,
  cafcu_out_if.source          out_ch
);

  logic                 valid_r;
  logic                 valid_nxt;
  cafcu_pkg::out_item_t res_r;

  // The register accepts a new result when empty or when this cycle's transfer drains it.
  assign free = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_ch.valid       = valid_r;
  assign out_ch.result      = res_r.result;
  assign out_ch.writes_back = res_r.writes_back;
  assign out_ch.flags_out   = res_r.flags_out;
  assign out_ch.cond_true   = res_r.cond_true;

endmodule

@@ rtl/cpu_alu_flags_condition_unit_core.sv @@
// 32-bit ALU with a Z/N/C/V status register and a branch-condition test. One operation
// is accepted per clock cycle, back to back, unless the result channel stalls. Each
// result is presented on the result channel once it has passed the input register and
// then the result register; it is held until taken. The combinational ALU path between
// those two registers sets the rate, and the status flags are written as the operation
// enters the result register, so the very next operation already sees them. Built from
// cafcu_pkg, the channel interfaces, cafcu_in_stage, cafcu_exec and cafcu_out_stage.
`include "cpu_alu_flags_condition_unit_core_defines.svh"

module cpu_alu_flags_condition_unit_core (
  input  logic        clk,
  input  logic        rst_n,
  cafcu_in_if.sink    in_ch,
  cafcu_out_if.source out_ch
);

  cafcu_pkg::in_item_t  item;
  logic                 item_valid;
  cafcu_pkg::out_item_t res;
  cafcu_pkg::flags_t    flags_r;
  cafcu_pkg::flags_t    flags_nxt;
  logic                 out_free;
  logic                 advance;

  // An operation moves to the result register when it is there and the slot is free.
  assign advance = item_valid && out_free;

  cafcu_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  cafcu_exec u_exec (
    .item      (item),
    .flags_q   (flags_r),
    .res       (res),
    .flags_nxt (flags_nxt)
  );

  cafcu_out_stage u_out_stage (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (advance),
    .res    (res),
    .free   (out_free),
    .out_ch (out_ch)
  );

  // Status register updates together with the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else if (advance) begin
      flags_r <= flags_nxt;
    end
  end

  // Flags only change when an operation completes.
  `CAFCU_ASSERT_NEXT(a_flags_hold, clk, rst_n, !advance,
                     flags_r == $past(flags_r), "flags changed without an operation")

  // The reported flags match the status register right after a load.
  `CAFCU_ASSERT_NEXT(a_flags_match, clk, rst_n, advance,
                     out_ch.flags_out == flags_r, "reported flags differ from status register")

  // A result that is not written back reads as zero.
  `CAFCU_ASSERT_IMPL(a_no_wb_zero, clk, rst_n, out_ch.valid && !out_ch.writes_back,
                     out_ch.result == '0, "result nonzero without write-back")

  // A true condition only comes from a condition test, which writes nothing.
  `CAFCU_ASSERT_IMPL(a_cond_no_wb, clk, rst_n, out_ch.valid && out_ch.cond_true,
                     !out_ch.writes_back, "condition result with write-back")

endmodule
